/* sv/sid_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sid_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int DIGIT_BITS = 2;
   localparam int ITER_COUNT = DATA_WIDTH / DIGIT_BITS;
   localparam int CNT_WIDTH  = $clog2(ITER_COUNT);

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] dividend;
      logic signed [DATA_WIDTH-1:0] divisor;
   } sid_req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] quotient;
      logic                         div_by_zero;
   } sid_rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic prep;
      logic step;
      logic finish;
   } sid_cmd_type;

endpackage

`default_nettype wire

/* sv/sid_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module sid_dp (
   input  wire                  clock,
   input  sid_pkg::sid_req_type req_payload,
   input  sid_pkg::sid_cmd_type cmd,
   output sid_pkg::sid_rsp_type rsp_payload
);
   import sid_pkg::*;

   logic [DATA_WIDTH-1:0]   a_ff, a_in;
   logic [DATA_WIDTH-1:0]   b_ff, b_in;
   logic [DATA_WIDTH+1:0]   b3_ff, b3_in;
   logic [DATA_WIDTH-1:0]   rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]   q_ff, q_in;
   logic                    neg_ff, neg_in;
   logic                    dz_ff, dz_in;
   sid_rsp_type             rsp_ff, rsp_in;

   logic [DATA_WIDTH-1:0]   num, den;
   logic [DATA_WIDTH+1:0]   part;
   logic [DATA_WIDTH+2:0]   d1, d2, d3;
   logic [DATA_WIDTH-1:0]   q_neg;

   assign num   = req_payload.dividend;
   assign den   = req_payload.divisor;
   assign part  = {rem_ff, a_ff[DATA_WIDTH-1 -: DIGIT_BITS]};
   assign d1    = {1'b0, part} - {3'b000, b_ff};
   assign d2    = {1'b0, part} - {2'b00, b_ff, 1'b0};
   assign d3    = {1'b0, part} - {1'b0, b3_ff};
   assign q_neg = ~q_ff + {{(DATA_WIDTH-1){1'b0}}, 1'b1};

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      b3_in  = b3_ff;
      rem_in = rem_ff;
      q_in   = q_ff;
      neg_in = neg_ff;
      dz_in  = dz_ff;
      rsp_in = rsp_ff;
      if (cmd.load) begin
         // take magnitudes; the most negative value stays 0x80000000 unsigned
         a_in   = num[DATA_WIDTH-1] ? (~num + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : num;
         b_in   = den[DATA_WIDTH-1] ? (~den + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : den;
         neg_in = num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
         dz_in  = (den == '0);
         rem_in = '0;
         q_in   = '0;
      end
      if (cmd.prep) begin
         b3_in = {2'b00, b_ff} + {1'b0, b_ff, 1'b0};
      end
      if (cmd.step) begin
         // radix-4 digit: pick the largest multiple that fits
         a_in = {a_ff[DATA_WIDTH-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
         if (!d3[DATA_WIDTH+2]) begin
            rem_in = d3[DATA_WIDTH-1:0];
            q_in   = {q_ff[DATA_WIDTH-DIGIT_BITS-1:0], 2'd3};
         end else if (!d2[DATA_WIDTH+2]) begin
            rem_in = d2[DATA_WIDTH-1:0];
            q_in   = {q_ff[DATA_WIDTH-DIGIT_BITS-1:0], 2'd2};
         end else if (!d1[DATA_WIDTH+2]) begin
            rem_in = d1[DATA_WIDTH-1:0];
            q_in   = {q_ff[DATA_WIDTH-DIGIT_BITS-1:0], 2'd1};
         end else begin
            rem_in = part[DATA_WIDTH-1:0];
            q_in   = {q_ff[DATA_WIDTH-DIGIT_BITS-1:0], 2'd0};
         end
      end
      if (cmd.finish) begin
         if (dz_ff) begin
            rsp_in.quotient = '0;
         end else if (neg_ff) begin
            rsp_in.quotient = q_neg;
         end else begin
            rsp_in.quotient = q_ff;
         end
         rsp_in.div_by_zero = dz_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      b3_ff  <= b3_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      dz_ff  <= dz_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

/* sv/sid_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module sid_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output sid_pkg::sid_cmd_type cmd
);
   import sid_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_ITER = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic [CNT_WIDTH-1:0] ITER_LAST = CNT_WIDTH'(ITER_COUNT - 1);

   logic [1:0]           state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == ITER_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* sv/signed_int32_divider.sv */
// Signed 32-bit divider, quotient truncated toward zero.
// Request channel (req_valid/req_ready/req_payload) carries dividend and
// divisor; response channel (rsp_valid/rsp_ready/rsp_payload) carries the
// quotient and a div_by_zero flag. A zero divisor gives quotient 0 with
// the flag set; the most negative value over minus one wraps to itself.
// One request is in flight at a time. req_ready is high only while the
// controller is idle. After acceptance: the prep state forms 3x the
// divisor magnitude, then 16 radix-4 passes of the shared compare/subtract
// unit retire two quotient bits each, then the done state applies the sign
// into the output register once that register is free.
// The output register lets the next request be accepted while a response
// waits; if the receiver still stalls when the next quotient is ready, the
// controller holds it until the output register frees up.
// Synchronous reset returns the controller to idle and drops rsp_valid.
`timescale 1ns / 1ps
`default_nettype none

module signed_int32_divider (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  sid_pkg::sid_req_type req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output sid_pkg::sid_rsp_type rsp_payload
);
   import sid_pkg::*;

   sid_cmd_type cmd;

   sid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sid_dp u_dp (
      .clock       (clock),
      .req_payload (req_payload),
      .cmd         (cmd),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
   import sid_pkg::*;

   localparam int RESET_CYCLES     = 9;
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int SETTLE_CYCLES    = 40;
   localparam int MAX_PRINTED      = 100;
   localparam int RANDOM_PER_PHASE = 440;
   localparam int LONG_GAP_MAX     = 40;

   localparam logic signed [DATA_WIDTH-1:0] MOST_NEG = 32'h8000_0000;
   localparam logic signed [DATA_WIDTH-1:0] MOST_POS = 32'h7FFF_FFFF;
   localparam logic signed [DATA_WIDTH-1:0] NIBBLE_TOP = 32'h1000_0000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   sid_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   sid_rsp_type rsp_payload;

   sid_rsp_type expected_quotients[$];
   int          mismatch_count = 0;
   int          send_idle_pct  = 0;
   int          rsp_stall_pct  = 0;
   int          stall_left     = 0;
   int          cycle_count    = 0;

   signed_int32_divider i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Quotient of the magnitudes, truncated, then signed by dividend XOR divisor.
   function automatic sid_rsp_type predict_quotient(input logic [DATA_WIDTH-1:0] num,
                                                    input logic [DATA_WIDTH-1:0] den);
      sid_rsp_type           result;
      logic [DATA_WIDTH-1:0] num_mag;
      logic [DATA_WIDTH-1:0] den_mag;
      logic [DATA_WIDTH-1:0] q;
      num_mag = num[DATA_WIDTH-1] ? (~num + 32'd1) : num;
      den_mag = den[DATA_WIDTH-1] ? (~den + 32'd1) : den;
      result  = '0;
      if (den_mag == '0) begin
         result.div_by_zero = 1'b1;
      end else begin
         q = num_mag / den_mag;
         if (num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1]) begin
            q = ~q + 32'd1;
         end
         result.quotient = q;
      end
      return result;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] random_operand();
      logic [DATA_WIDTH-1:0] v;
      case ($urandom_range(7))
         0: v = $urandom;
         1: begin
            case ($urandom_range(5))
               0: v = MOST_NEG;
               1: v = MOST_POS;
               2: v = '1;
               3: v = 32'd1;
               4: v = NIBBLE_TOP;
               default: v = '0;
            endcase
         end
         default: begin
            // spread the magnitudes so quotients of every size show up
            v = $urandom >> $urandom_range(DATA_WIDTH-1);
            if ($urandom_range(1)) begin
               v = ~v + 32'd1;
            end
         end
      endcase
      return v;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_WIDTH-1:0] got,
                                  input logic [DATA_WIDTH-1:0] want);
      if (mismatch_count < MAX_PRINTED) begin
         $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
      end
      mismatch_count++;
   endtask

   // Receiver side: random stalls, now and then a long one, and the result check.
   always @(posedge clock) begin : rsp_checker
      sid_rsp_type want;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(99) < rsp_stall_pct) begin
         rsp_ready <= 1'b0;
         if ($urandom_range(7) == 0) begin
            stall_left <= $urandom_range(5, LONG_GAP_MAX);
         end
      end else begin
         rsp_ready <= 1'b1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_quotients.size() == 0) begin
            report_mismatch("response with no request pending", rsp_payload.quotient, '0);
         end else begin
            want = expected_quotients.pop_front();
            if (rsp_payload.quotient !== want.quotient) begin
               report_mismatch("quotient", rsp_payload.quotient, want.quotient);
            end
            if (rsp_payload.div_by_zero !== want.div_by_zero) begin
               report_mismatch("div_by_zero", DATA_WIDTH'(rsp_payload.div_by_zero),
                               DATA_WIDTH'(want.div_by_zero));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Leaves req_valid high on return so the next request can follow back to back.
   task automatic send_division(input logic signed [DATA_WIDTH-1:0] num,
                                input logic signed [DATA_WIDTH-1:0] den);
      sid_req_type item;
      item.dividend = num;
      item.divisor  = den;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, LONG_GAP_MAX)) @(posedge clock);
         end else begin
            do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
         end
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      expected_quotients.push_back(predict_quotient(num, den));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_quotients.size() != 0);
   endtask

   task automatic run_random_batch(input int count);
      for (int n = 0; n < count; n++) begin
         send_division(random_operand(), random_operand());
         // hold off now and then until every result is back
         if ($urandom_range(49) == 0) begin
            wait_drained();
         end
      end
      wait_drained();
   endtask

   task automatic test_corner_cases();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_division(32'sd100, 32'sd7);
      send_division(-32'sd100, 32'sd7);
      send_division(32'sd100, -32'sd7);
      send_division(-32'sd100, -32'sd7);
      send_division(-32'sd7, 32'sd2);
      send_division(32'sd7, 32'sd100);
      send_division(32'sd0, 32'sd5);
      send_division(32'sd5, 32'sd0);
      send_division(32'sd0, 32'sd0);
      send_division(MOST_NEG, 32'sd0);
      send_division(MOST_NEG, -32'sd1);
      send_division(MOST_NEG, 32'sd1);
      send_division(MOST_NEG, MOST_NEG);
      send_division(MOST_NEG, MOST_POS);
      send_division(MOST_POS, MOST_NEG);
      send_division(MOST_NEG, 32'sd2);
      send_division(MOST_POS, 32'sd1);
      send_division(MOST_POS, -32'sd1);
      send_division(MOST_POS, MOST_POS);
      send_division(-32'sd1, MOST_NEG);
      send_division(MOST_POS, NIBBLE_TOP);
      send_division(NIBBLE_TOP, 32'sd1);
      send_division(32'h5555_5555, 32'sd3);
      send_division(32'h1234_5678, 32'sd16);
      wait_drained();
   endtask

   task automatic test_back_to_back();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random_batch(RANDOM_PER_PHASE);
   endtask

   task automatic test_sender_gaps();
      send_idle_pct = 61;
      rsp_stall_pct = 0;
      run_random_batch(RANDOM_PER_PHASE);
   endtask

   task automatic test_receiver_stalls();
      send_idle_pct = 0;
      rsp_stall_pct = 61;
      run_random_batch(RANDOM_PER_PHASE);
   endtask

   task automatic test_mixed_idle();
      send_idle_pct = 23;
      rsp_stall_pct = 23;
      run_random_batch(RANDOM_PER_PHASE);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_cases();
      test_back_to_back();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_quotients.size() != 0) begin
         report_mismatch("requests left without a response", expected_quotients.size(), '0);
      end
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
